// ===== hw/rtl/olt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_pkg
// Shared widths, operation and status codes and inter-module structs for
// the ordered list table.
// ----------------------------------------------------------------------------
package olt_pkg;

  localparam int DEFAULT_DEPTH     = 64;
  localparam int DEFAULT_WORD_BITS = 32;

  localparam int MODE_W   = 3;
  localparam int POS_W    = 6;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 7;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FIND   = 3'd5;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  typedef struct packed {
    logic    valid;
    logic    found;
    status_e status;
  } res_t;

endpackage
`default_nettype wire

// ===== hw/rtl/olt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_mem
// Entry storage: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module olt_mem #(
  parameter int DEPTH     = olt_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = olt_pkg::DEFAULT_WORD_BITS
) (
  input  wire logic                     clk_i,
  input  wire olt_pkg::mem_ctl_t        ctl_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WORD_BITS-1:0]     wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WORD_BITS-1:0]     rdata_o
);
  import olt_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/olt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// olt_ctrl
// Request sequencer: dispatches each operation, walks the memory for delete
// compaction and find, and holds the entry count.
// ----------------------------------------------------------------------------
module olt_ctrl #(
  parameter int DEPTH     = olt_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = olt_pkg::DEFAULT_WORD_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  input  wire logic [olt_pkg::MODE_W-1:0]   mode_i,
  input  wire logic [olt_pkg::POS_W-1:0]    pos_i,
  input  wire logic [WORD_BITS-1:0]         word_i,
  output logic                              busy_o,
  input  wire logic                         slot_free_i,
  output olt_pkg::mem_ctl_t                 mem_ctl_o,
  output logic [$clog2(DEPTH)-1:0]          mem_waddr_o,
  output logic [WORD_BITS-1:0]              mem_wdata_o,
  output logic [$clog2(DEPTH)-1:0]          mem_raddr_o,
  input  wire logic [WORD_BITS-1:0]         mem_rdata_i,
  output olt_pkg::res_t                     res_o,
  output logic [WORD_BITS-1:0]              res_word_o,
  output logic [$clog2(DEPTH+1)-1:0]        count_o
);
  import olt_pkg::*;

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_FIND = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]        wr_ptr_q, wr_ptr_d;
  logic                 pend_q, pend_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [WORD_BITS-1:0] res_word_q, res_word_d;
  logic                 res_found_q, res_found_d;
  status_e              res_status_q, res_status_d;

  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CW-1:0]   cnt_dec;
  logic            pos_ok;
  logic            ptr_lt;
  logic            hit;

  assign pos_ext = CMPW'(pos_i);
  assign cnt_ext = CMPW'(count_q);
  assign cnt_dec = count_q - CW'(1);
  assign pos_ok  = pos_ext < cnt_ext;
  assign ptr_lt  = rd_ptr_q < count_q;
  assign hit     = mem_rdata_i == word_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    pend_d       = pend_q;
    word_d       = word_q;
    res_word_d   = res_word_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    mem_ctl_o    = '0;
    mem_waddr_o  = '0;
    mem_wdata_o  = word_i;
    mem_raddr_o  = '0;
    res_o        = '0;
    res_o.status = res_status_q;
    res_o.found  = res_found_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          word_d       = word_i;
          res_word_d   = '0;
          res_found_d  = 1'b0;
          res_status_d = ST_OK;
          state_d      = S_DONE;
          case (mode_i)
            MODE_APPEND: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_ctl_o.wr_en = 1'b1;
                mem_waddr_o     = count_q[AW-1:0];
                count_d         = count_q + CW'(1);
              end
            end
            MODE_READ: begin
              if (pos_ok) begin
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = pos_ext[AW-1:0];
                state_d         = S_RD;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            MODE_WRITE: begin
              if (pos_ok) begin
                mem_ctl_o.wr_en = 1'b1;
                mem_waddr_o     = pos_ext[AW-1:0];
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            MODE_DELETE: begin
              if (pos_ok) begin
                wr_ptr_d = pos_ext[AW-1:0];
                rd_ptr_d = pos_ext[CW-1:0] + CW'(1);
                pend_d   = 1'b0;
                state_d  = S_DEL;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            MODE_POP: begin
              if (count_q != '0) begin
                count_d         = cnt_dec;
                mem_ctl_o.rd_en = 1'b1;
                mem_raddr_o     = cnt_dec[AW-1:0];
                state_d         = S_RD;
              end else begin
                res_status_d = ST_RANGE;
              end
            end
            MODE_FIND: begin
              rd_ptr_d = '0;
              pend_d   = 1'b0;
              state_d  = S_FIND;
            end
            default: begin
              res_status_d = ST_RANGE;
            end
          endcase
        end
      end
      S_RD: begin
        res_word_d = mem_rdata_i;
        state_d    = S_DONE;
      end
      S_DEL: begin
        // move the word read last beat down one place while reading the next
        if (pend_q) begin
          mem_ctl_o.wr_en = 1'b1;
          mem_waddr_o     = wr_ptr_q;
          mem_wdata_o     = mem_rdata_i;
          wr_ptr_d        = wr_ptr_q + AW'(1);
        end
        if (ptr_lt) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = rd_ptr_q[AW-1:0];
          rd_ptr_d        = rd_ptr_q + CW'(1);
          pend_d          = 1'b1;
        end else begin
          pend_d  = 1'b0;
          count_d = cnt_dec;
          state_d = S_DONE;
        end
      end
      S_FIND: begin
        if (pend_q && hit) begin
          res_found_d = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_DONE;
        end else if (ptr_lt) begin
          mem_ctl_o.rd_en = 1'b1;
          mem_raddr_o     = rd_ptr_q[AW-1:0];
          rd_ptr_d        = rd_ptr_q + CW'(1);
          pend_d          = 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q       <= word_d;
    res_word_q   <= res_word_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
  end

  assign busy_o     = state_q != S_IDLE;
  assign res_word_o = res_word_q;
  assign count_o    = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ordered_list_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_list_table
// Fixed-capacity ordered list of words with append, read, write, compacting
// delete, pop and find, one result beat per request beat.
// ----------------------------------------------------------------------------
// Takes one request at a time; in_stall_o follows the registered sequencer
// state, so it rises once a request beat is taken and stays high until its
// result has been moved into the output register. Append, write and every
// refused request go straight to the result; read and pop pass a read state
// first. Delete at position p and find walk the entry memory one entry per
// cycle through its single read port. No clearing pass after reset. A new
// request may be taken while the prior result waits in the output register.
module ordered_list_table #(
  parameter int DEPTH     = olt_pkg::DEFAULT_DEPTH,
  parameter int WORD_BITS = olt_pkg::DEFAULT_WORD_BITS
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [olt_pkg::MODE_W-1:0]     mode_i,
  input  wire logic [olt_pkg::POS_W-1:0]      position_i,
  input  wire logic [olt_pkg::DATA_W-1:0]     data_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [olt_pkg::DATA_W-1:0]          read_word_o,
  output logic                                found_o,
  output logic [olt_pkg::STATUS_W-1:0]        status_o,
  output logic [olt_pkg::TOTAL_W-1:0]         entry_total_o
);
  import olt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic                          busy;
  logic                          slot_free;
  mem_ctl_t                      mem_ctl;
  logic [AW-1:0]                 mem_waddr;
  logic [AW-1:0]                 mem_raddr;
  logic [WORD_BITS-1:0]          mem_wdata;
  logic [WORD_BITS-1:0]          mem_rdata;
  res_t                          res;
  logic [WORD_BITS-1:0]          res_word;
  logic [CW-1:0]                 count;

  logic [WORD_BITS+DATA_W-1:0]   word_ext;
  logic [WORD_BITS-1:0]          word;
  logic [DATA_W+WORD_BITS-1:0]   rd_ext;
  logic [TOTAL_W+CW-1:0]         total_ext;

  logic                          out_valid_q;
  logic [DATA_W-1:0]             read_word_q;
  logic                          found_q;
  logic [STATUS_W-1:0]           status_q;
  logic [TOTAL_W-1:0]            total_q;

  assign word_ext  = {{WORD_BITS{1'b0}}, data_word_i};
  assign word      = word_ext[WORD_BITS-1:0];
  assign rd_ext    = {{DATA_W{1'b0}}, res_word};
  assign total_ext = {{TOTAL_W{1'b0}}, count};

  assign in_stall_o = busy;
  assign slot_free  = !out_valid_q || !out_stall_i;

  olt_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .pos_i       (position_i),
    .word_i      (word),
    .busy_o      (busy),
    .slot_free_i (slot_free),
    .mem_ctl_o   (mem_ctl),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_o       (res),
    .res_word_o  (res_word),
    .count_o     (count)
  );

  olt_mem #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      read_word_q <= rd_ext[DATA_W-1:0];
      found_q     <= res.found;
      status_q    <= res.status;
      total_q     <= total_ext[TOTAL_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_word_o   = read_word_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_total_o = total_q;

endmodule
`default_nettype wire
